FILE: src/hmn_pkg.sv
// Shared types, constants and helpers for the heightmap normal stencil.
// No dependencies; every other file in src takes this package in.
`timescale 1ns / 1ps
`default_nettype none

package hmn_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 8192;
  localparam int HEIGHT_BITS_DEF    = 24;

  // Configuration register widths and reset values
  localparam int ROW_LENGTH_W = 14;
  localparam int ROW_COUNT_W  = 16;
  localparam int SPACING_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = ROW_LENGTH_W'(1024);
  localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = ROW_COUNT_W'(1024);
  localparam logic [SPACING_W-1:0]    SPACING_RST    = SPACING_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_GRID_SPACING = 2'd2
  } cfg_reg_t;

  // Up component is spacing * 2 * 256 (heights carry eight fraction bits)
  localparam int UP_SHIFT = 9;
  localparam int UP_W     = SPACING_W + UP_SHIFT;

  // Q1.14 output magnitudes span 0..16384
  localparam int NORM_W    = 15;
  localparam int NORM_FRAC = 14;
  localparam int Q_TOP     = NORM_W - 1;
  localparam int Q_STEPS   = NORM_W;
  localparam int R_SHIFT   = 2 * NORM_FRAC + 2;
  localparam logic [NORM_W-1:0] ONE_Q14 = NORM_W'(16384);

  localparam int LANES = 3;

  typedef struct packed {
    logic [ROW_COUNT_W-1:0] row;
    logic                   emit_a;
    logic                   emit_b;
    logic                   interior;
    logic                   neg_x;
    logic                   neg_z;
  } item_meta_t;

  function automatic int mag_width(input int hb);
    return (hb > UP_W) ? hb : UP_W;
  endfunction

endpackage

`default_nettype wire

FILE: src/hmn_ifs.sv
// Stream interfaces: height samples in, normal words out.
// Depends on hmn_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface hmn_height_if #(
  parameter int HEIGHT_BITS = hmn_pkg::HEIGHT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_sample;

  modport source(output valid, height_sample, input ready);
  modport sink(input valid, height_sample, output ready);
endinterface

interface hmn_normal_if #(
  parameter int COL_W = 13
) ();
  logic                     valid;
  logic                     ready;
  logic [COL_W-1:0]         column;
  logic [15:0]              row;
  logic signed [15:0]       normal_x;
  logic [14:0]              normal_y;
  logic signed [15:0]       normal_z;
  logic                     last_of_run;

  modport source(output valid, column, row, normal_x, normal_y, normal_z, last_of_run,
                 input ready);
  modport sink(input valid, column, row, normal_x, normal_y, normal_z, last_of_run,
               output ready);
endinterface

`default_nettype wire

FILE: src/hmn_front.sv
// Raster position tracking, line memory and stencil differences (stages A and B).
// Depends on hmn_pkg and hmn_height_if.
`timescale 1ns / 1ps
`default_nettype none

module hmn_front #(
  parameter int MAX_ROW_LENGTH = hmn_pkg::MAX_ROW_LENGTH_DEF,
  parameter int HEIGHT_BITS    = hmn_pkg::HEIGHT_BITS_DEF,
  localparam int COL_W  = $clog2(MAX_ROW_LENGTH),
  localparam int DIFF_W = HEIGHT_BITS + 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [hmn_pkg::ROW_LENGTH_W-1:0]      row_length,
  input  logic [hmn_pkg::ROW_COUNT_W-1:0]       row_count,
  input  logic [hmn_pkg::SPACING_W-1:0]         grid_spacing,
  hmn_height_if.sink                            samples,
  output logic                                  b_valid,
  input  logic                                  down_take,
  output logic [COL_W-1:0]                      b_col,
  output hmn_pkg::item_meta_t                   b_meta,
  output logic signed [DIFF_W-1:0]              b_dx,
  output logic signed [DIFF_W-1:0]              b_dz,
  output logic [hmn_pkg::UP_W-1:0]              b_up
);
  import hmn_pkg::*;

  localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_LENGTH);
  localparam int HB = HEIGHT_BITS;

  logic [LEN_W-1:0]       len_eff;
  logic [ROW_COUNT_W-1:0] cnt_eff;
  logic [SPACING_W-1:0]   spacing_eff;

  logic [COL_W-1:0]       col_pos, col_pos_next;
  logic [ROW_COUNT_W-1:0] row_pos, row_pos_next;
  logic [COL_W-1:0]       c_cur, c_nb;
  logic [ROW_COUNT_W-1:0] r_cur;
  logic [ROW_COUNT_W:0]   r_tmp, r_inc;
  logic [LEN_W-1:0]       c_plus;
  logic                   last_col;
  item_meta_t             in_meta;

  logic                   accept, take_a, take_b, a_pass;
  logic                   a_valid;
  logic [COL_W-1:0]       a_col;
  item_meta_t             a_meta;
  logic signed [HB-1:0]   a_h, a_newer, a_older, a_right, left;
  logic [UP_W-1:0]        a_up;

  // Each entry holds {row r-1, row r-2} for its column
  logic [2*HB-1:0]        line_mem [MAX_ROW_LENGTH];

  always_comb begin
    if (row_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(row_length) > MAX_ROW_LENGTH) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LEN_W'(row_length);
    end
    cnt_eff     = (row_count == '0) ? ROW_COUNT_W'(1) : row_count;
    spacing_eff = (grid_spacing == '0) ? SPACING_W'(1) : grid_spacing;
  end

  // Wrap the stored position against the sizes in force now
  always_comb begin
    if (LEN_W'(col_pos) >= len_eff) begin
      c_cur = '0;
      r_tmp = {1'b0, row_pos} + 1'b1;
    end else begin
      c_cur = col_pos;
      r_tmp = {1'b0, row_pos};
    end
    r_cur    = (r_tmp >= {1'b0, cnt_eff}) ? '0 : r_tmp[ROW_COUNT_W-1:0];
    c_nb     = c_cur + COL_W'(1);
    last_col = (LEN_W'(c_cur) == len_eff - LEN_W'(1));
    c_plus   = LEN_W'(c_cur) + LEN_W'(1);
    r_inc    = {1'b0, r_cur} + 1'b1;
    if (c_plus >= len_eff) begin
      col_pos_next = '0;
      row_pos_next = (r_inc >= {1'b0, cnt_eff}) ? '0 : r_inc[ROW_COUNT_W-1:0];
    end else begin
      col_pos_next = c_plus[COL_W-1:0];
      row_pos_next = r_cur;
    end
    in_meta.row      = r_cur;
    in_meta.emit_a   = (r_cur != '0);
    in_meta.emit_b   = (r_cur == cnt_eff - ROW_COUNT_W'(1));
    in_meta.interior = (r_cur >= ROW_COUNT_W'(2)) && (c_cur != '0) && !last_col;
    in_meta.neg_x    = 1'b0;
    in_meta.neg_z    = 1'b0;
  end

  assign take_b        = !b_valid || down_take;
  assign take_a        = !a_valid || take_b;
  assign a_pass        = a_valid && take_b;
  assign accept        = samples.valid && take_a;
  assign samples.ready = take_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
      end
      if (take_a) begin
        a_valid <= samples.valid;
      end
      if (take_b) begin
        b_valid <= a_valid;
      end
    end
  end

  // Line memory: two reads on accept, one write as the word leaves stage A
  always_ff @(posedge clk) begin
    if (accept) begin
      a_newer <= line_mem[c_cur][2*HB-1:HB];
      a_older <= line_mem[c_cur][HB-1:0];
      a_right <= line_mem[c_nb][2*HB-1:HB];
    end
    if (a_pass) begin
      line_mem[a_col] <= {a_h, a_newer};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col  <= c_cur;
      a_meta <= in_meta;
      a_h    <= samples.height_sample;
      a_up   <= {spacing_eff, {UP_SHIFT{1'b0}}};
    end
    if (a_pass) begin
      // left neighbor of the next column is this column of row r-1
      left   <= a_newer;
      b_col  <= a_col;
      b_meta <= a_meta;
      b_up   <= a_up;
      b_dx   <= DIFF_W'(left) - DIFF_W'(a_right);
      b_dz   <= DIFF_W'(a_older) - DIFF_W'(a_h);
    end
  end

endmodule

`default_nettype wire

FILE: src/hmn_prep.sv
// Magnitudes, squares, squared length and quantizer seed (stages C to F).
// Depends on hmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmn_prep #(
  parameter int MAX_ROW_LENGTH = hmn_pkg::MAX_ROW_LENGTH_DEF,
  parameter int HEIGHT_BITS    = hmn_pkg::HEIGHT_BITS_DEF,
  localparam int COL_W  = $clog2(MAX_ROW_LENGTH),
  localparam int DIFF_W = HEIGHT_BITS + 1,
  localparam int MAG_W  = hmn_pkg::mag_width(HEIGHT_BITS),
  localparam int SQ_W   = 2 * MAG_W,
  localparam int S_W    = SQ_W + 2,
  localparam int D_W    = S_W + 34,
  localparam int Q_W    = S_W + 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         take_out,
  input  logic [COL_W-1:0]             in_col,
  input  hmn_pkg::item_meta_t          in_meta,
  input  logic signed [DIFF_W-1:0]     in_dx,
  input  logic signed [DIFF_W-1:0]     in_dz,
  input  logic [hmn_pkg::UP_W-1:0]     in_up,
  output logic                         out_valid,
  input  logic                         down_take,
  output logic [COL_W-1:0]             out_col,
  output hmn_pkg::item_meta_t          out_meta,
  output logic [S_W-1:0]               out_s,
  output logic signed [D_W-1:0]        out_d  [hmn_pkg::LANES],
  output logic signed [Q_W-1:0]        out_qa [hmn_pkg::LANES]
);
  import hmn_pkg::*;

  logic              c_valid, d_valid, e_valid;
  logic              take_c, take_d, take_e, take_f;
  logic [COL_W-1:0]  c_col, d_col, e_col;
  item_meta_t        c_meta, d_meta, e_meta;
  item_meta_t        in_meta_sgn;
  logic [MAG_W-1:0]  c_mag [LANES];
  logic [SQ_W-1:0]   d_sq  [LANES];
  logic [SQ_W-1:0]   e_sq  [LANES];
  logic [S_W-1:0]    e_s;
  logic signed [DIFF_W-1:0] abs_x, abs_z;

  assign take_f   = !out_valid || down_take;
  assign take_e   = !e_valid || take_f;
  assign take_d   = !d_valid || take_e;
  assign take_c   = !c_valid || take_d;
  assign take_out = take_c;

  assign abs_x = in_dx[DIFF_W-1] ? -in_dx : in_dx;
  assign abs_z = in_dz[DIFF_W-1] ? -in_dz : in_dz;

  // Carry the difference signs along with the rest of the item
  always_comb begin
    in_meta_sgn       = in_meta;
    in_meta_sgn.neg_x = in_dx[DIFF_W-1];
    in_meta_sgn.neg_z = in_dz[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_c) c_valid   <= in_valid;
      if (take_d) d_valid   <= c_valid;
      if (take_e) e_valid   <= d_valid;
      if (take_f) out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_c) begin
      c_col        <= in_col;
      c_meta       <= in_meta_sgn;
      c_mag[0]     <= MAG_W'($unsigned(abs_x));
      c_mag[1]     <= MAG_W'(in_up);
      c_mag[2]     <= MAG_W'($unsigned(abs_z));
    end
    if (take_d) begin
      d_col  <= c_col;
      d_meta <= c_meta;
      for (int i = 0; i < LANES; i++) begin
        d_sq[i] <= SQ_W'(c_mag[i]) * SQ_W'(c_mag[i]);
      end
    end
    if (take_e) begin
      e_col  <= d_col;
      e_meta <= d_meta;
      e_sq   <= d_sq;
      e_s    <= S_W'(d_sq[0]) + S_W'(d_sq[1]) + S_W'(d_sq[2]);
    end
    if (take_f) begin
      out_col  <= e_col;
      out_meta <= e_meta;
      out_s    <= e_s;
      // seed for q = 0: remainder = (mag << 15)^2 - s, running term = -s
      for (int i = 0; i < LANES; i++) begin
        out_d[i]  <= $signed((D_W'(e_sq[i]) << R_SHIFT) - D_W'(e_s));
        out_qa[i] <= $signed(-Q_W'(e_s));
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/hmn_qstep.sv
// One bit of the rounding quantizer for all three lanes, one register stage.
// Depends on hmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmn_qstep #(
  parameter int MAX_ROW_LENGTH = hmn_pkg::MAX_ROW_LENGTH_DEF,
  parameter int HEIGHT_BITS    = hmn_pkg::HEIGHT_BITS_DEF,
  parameter int K              = hmn_pkg::Q_TOP,
  localparam int COL_W = $clog2(MAX_ROW_LENGTH),
  localparam int MAG_W = hmn_pkg::mag_width(HEIGHT_BITS),
  localparam int S_W   = 2 * MAG_W + 2,
  localparam int D_W   = S_W + 34,
  localparam int Q_W   = S_W + 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         take_out,
  input  logic [COL_W-1:0]             in_col,
  input  hmn_pkg::item_meta_t          in_meta,
  input  logic [S_W-1:0]               in_s,
  input  logic signed [D_W-1:0]        in_d  [hmn_pkg::LANES],
  input  logic signed [Q_W-1:0]        in_qa [hmn_pkg::LANES],
  input  logic [hmn_pkg::NORM_W-1:0]   in_q  [hmn_pkg::LANES],
  output logic                         out_valid,
  input  logic                         down_take,
  output logic [COL_W-1:0]             out_col,
  output hmn_pkg::item_meta_t          out_meta,
  output logic [S_W-1:0]               out_s,
  output logic signed [D_W-1:0]        out_d  [hmn_pkg::LANES],
  output logic signed [Q_W-1:0]        out_qa [hmn_pkg::LANES],
  output logic [hmn_pkg::NORM_W-1:0]   out_q  [hmn_pkg::LANES]
);
  import hmn_pkg::*;

  logic                  take;
  logic signed [D_W-1:0] delta [LANES];
  logic signed [D_W-1:0] dn    [LANES];
  logic                  ok    [LANES];
  logic signed [D_W-1:0] d_nx  [LANES];
  logic signed [Q_W-1:0] qa_nx [LANES];
  logic [NORM_W-1:0]     q_nx  [LANES];

  assign take     = !out_valid || down_take;
  assign take_out = take;

  // Try setting bit K: (2q'-1)^2 s = (2q-1)^2 s + (2q-1)s*2^(K+2) + s*2^(2K+2)
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      delta[i] = (D_W'(in_qa[i]) <<< (K + 2)) + $signed(D_W'(in_s) << (2 * K + 2));
      dn[i]    = in_d[i] - delta[i];
      ok[i]    = !dn[i][D_W-1] && ((K == Q_TOP) || !in_q[i][Q_TOP]);
      d_nx[i]  = ok[i] ? dn[i] : in_d[i];
      qa_nx[i] = ok[i] ? in_qa[i] + $signed(Q_W'(in_s) << (K + 1)) : in_qa[i];
      q_nx[i]  = in_q[i];
      q_nx[i][K] = ok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_col  <= in_col;
      out_meta <= in_meta;
      out_s    <= in_s;
      out_d    <= d_nx;
      out_qa   <= qa_nx;
      out_q    <= q_nx;
    end
  end

endmodule

`default_nettype wire

FILE: src/hmn_out.sv
// Output register: sends one or two normal words per item and drops items
// that cause none. Depends on hmn_pkg and hmn_normal_if.
`timescale 1ns / 1ps
`default_nettype none

module hmn_out #(
  parameter int MAX_ROW_LENGTH = hmn_pkg::MAX_ROW_LENGTH_DEF,
  localparam int COL_W = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       take_out,
  input  logic [COL_W-1:0]           in_col,
  input  hmn_pkg::item_meta_t        in_meta,
  input  logic [hmn_pkg::NORM_W-1:0] in_q [hmn_pkg::LANES],
  hmn_normal_if.source               normals
);
  import hmn_pkg::*;

  logic               o_valid, o_phase;
  logic [COL_W-1:0]   o_col;
  item_meta_t         o_meta;
  logic signed [15:0] o_nx, o_nz;
  logic [NORM_W-1:0]  o_ny;
  logic               sel_b, last_word, take;

  assign sel_b     = o_phase || !o_meta.emit_a;
  assign last_word = sel_b || !o_meta.emit_b;
  assign take      = !o_valid || (normals.ready && last_word);
  assign take_out  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_phase <= 1'b0;
    end else if (take) begin
      o_valid <= in_valid && (in_meta.emit_a || in_meta.emit_b);
      o_phase <= 1'b0;
    end else if (normals.ready) begin
      o_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_col  <= in_col;
      o_meta <= in_meta;
      if (in_meta.interior) begin
        o_nx <= in_meta.neg_x ? -$signed({1'b0, in_q[0]}) : $signed({1'b0, in_q[0]});
        o_ny <= in_q[1];
        o_nz <= in_meta.neg_z ? -$signed({1'b0, in_q[2]}) : $signed({1'b0, in_q[2]});
      end else begin
        o_nx <= '0;
        o_ny <= ONE_Q14;
        o_nz <= '0;
      end
    end
  end

  // First word is the row above, second the last row's own border point
  assign normals.valid       = o_valid;
  assign normals.column      = o_col;
  assign normals.row         = sel_b ? o_meta.row : o_meta.row - ROW_COUNT_W'(1);
  assign normals.normal_x    = sel_b ? '0 : o_nx;
  assign normals.normal_y    = sel_b ? ONE_Q14 : o_ny;
  assign normals.normal_z    = sel_b ? '0 : o_nz;
  assign normals.last_of_run = last_word;

endmodule

`default_nettype wire

FILE: src/heightmap_normal_stencil.sv
// Top level of the heightmap normal stencil: config registers and pipeline.
// Depends on hmn_pkg, hmn_ifs, hmn_front, hmn_prep, hmn_qstep and hmn_out.
`timescale 1ns / 1ps
`default_nettype none

// Heightmap samples (signed Q15.8) arrive in raster order on "samples", one word
// per clock when the output keeps up; each sample of row r >= 1 produces the unit
// normal of the same column in row r-1, and each sample of the last row also
// produces its own border normal, so "normals" carries up to two words per sample
// and last_of_run marks the final one. Throughput is one sample per cycle, except
// that a sample causing two words holds the output register until both are sent,
// which pauses the input once any upstream bubbles are used up. From accept to the
// first word a sample passes two stages for position and the line memory read,
// four for magnitudes, squares, the squared length and the quantizer seed, fifteen
// for the rounding quantizer (one result bit per stage, all three lanes side by
// side), and the output register. One line memory of MAX_ROW_LENGTH entries, each
// holding the two previous rows of a column, is read at two addresses and written
// at one per cycle; it is not cleared after reset, so the first two rows of a
// frame only produce border normals from it. Configuration takes effect on the
// next sample; the user must write it only while the pipeline is empty, and the block does not enforce it.

module heightmap_normal_stencil #(
  parameter int MAX_ROW_LENGTH = hmn_pkg::MAX_ROW_LENGTH_DEF,
  parameter int HEIGHT_BITS    = hmn_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hmn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmn_pkg::CFG_DATA_W-1:0]  cfg_data,
  hmn_height_if.sink                      samples,
  hmn_normal_if.source                    normals
);
  import hmn_pkg::*;

  localparam int COL_W  = $clog2(MAX_ROW_LENGTH);
  localparam int DIFF_W = HEIGHT_BITS + 1;
  localparam int MAG_W  = mag_width(HEIGHT_BITS);
  localparam int S_W    = 2 * MAG_W + 2;
  localparam int D_W    = S_W + 34;
  localparam int Q_W    = S_W + 17;

  logic [ROW_LENGTH_W-1:0] row_length;
  logic [ROW_COUNT_W-1:0]  row_count;
  logic [SPACING_W-1:0]    grid_spacing;

  // Front to prep
  logic                     b_valid, prep_take;
  logic [COL_W-1:0]         b_col;
  item_meta_t               b_meta;
  logic signed [DIFF_W-1:0] b_dx, b_dz;
  logic [UP_W-1:0]          b_up;

  // Quantizer chain: entry 0 is the seed, entry i+1 leaves step i
  logic                  st_valid [Q_STEPS+1];
  logic                  st_take  [Q_STEPS+1];
  logic [COL_W-1:0]      st_col   [Q_STEPS+1];
  item_meta_t            st_meta  [Q_STEPS+1];
  logic [S_W-1:0]        st_s     [Q_STEPS+1];
  logic signed [D_W-1:0] st_d     [Q_STEPS+1][LANES];
  logic signed [Q_W-1:0] st_qa    [Q_STEPS+1][LANES];
  logic [NORM_W-1:0]     st_q     [Q_STEPS+1][LANES];

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= ROW_LENGTH_RST;
      row_count    <= ROW_COUNT_RST;
      grid_spacing <= SPACING_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_LENGTH:   row_length   <= cfg_data[ROW_LENGTH_W-1:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[ROW_COUNT_W-1:0];
        REG_GRID_SPACING: grid_spacing <= cfg_data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  hmn_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .HEIGHT_BITS   (HEIGHT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .row_length  (row_length),
    .row_count   (row_count),
    .grid_spacing(grid_spacing),
    .samples     (samples),
    .b_valid     (b_valid),
    .down_take   (prep_take),
    .b_col       (b_col),
    .b_meta      (b_meta),
    .b_dx        (b_dx),
    .b_dz        (b_dz),
    .b_up        (b_up)
  );

  hmn_prep #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .HEIGHT_BITS   (HEIGHT_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .take_out (prep_take),
    .in_col   (b_col),
    .in_meta  (b_meta),
    .in_dx    (b_dx),
    .in_dz    (b_dz),
    .in_up    (b_up),
    .out_valid(st_valid[0]),
    .down_take(st_take[0]),
    .out_col  (st_col[0]),
    .out_meta (st_meta[0]),
    .out_s    (st_s[0]),
    .out_d    (st_d[0]),
    .out_qa   (st_qa[0])
  );

  // Quantizer starts from q = 0 in every lane
  for (genvar l = 0; l < LANES; l++) begin : g_seed
    assign st_q[0][l] = '0;
  end

  // Resolve bits 14 down to 0, one per stage
  for (genvar i = 0; i < Q_STEPS; i++) begin : g_step
    hmn_qstep #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
      .HEIGHT_BITS   (HEIGHT_BITS),
      .K             (Q_TOP - i)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[i]),
      .take_out (st_take[i]),
      .in_col   (st_col[i]),
      .in_meta  (st_meta[i]),
      .in_s     (st_s[i]),
      .in_d     (st_d[i]),
      .in_qa    (st_qa[i]),
      .in_q     (st_q[i]),
      .out_valid(st_valid[i+1]),
      .down_take(st_take[i+1]),
      .out_col  (st_col[i+1]),
      .out_meta (st_meta[i+1]),
      .out_s    (st_s[i+1]),
      .out_d    (st_d[i+1]),
      .out_qa   (st_qa[i+1]),
      .out_q    (st_q[i+1])
    );
  end

  hmn_out #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .in_valid(st_valid[Q_STEPS]),
    .take_out(st_take[Q_STEPS]),
    .in_col  (st_col[Q_STEPS]),
    .in_meta (st_meta[Q_STEPS]),
    .in_q    (st_q[Q_STEPS]),
    .normals (normals)
  );

  // A first word of a pair is followed by the border word one row further down
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    normals.valid && normals.ready && !normals.last_of_run |=>
      normals.valid && normals.row == $past(normals.row) + 16'd1 &&
      normals.column == $past(normals.column))
    else $error("second word of a pair has wrong position");

  // Column 0 is always a border point
  a_left_border: assert property (@(posedge clk) disable iff (rst)
    normals.valid && normals.column == '0 |->
      normals.normal_x == '0 && normals.normal_z == '0 &&
      normals.normal_y == ONE_Q14)
    else $error("left border normal is not straight up");

  // Quantized x and y components never exceed one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    normals.valid |-> normals.normal_y <= ONE_Q14 &&
      normals.normal_x <= $signed({1'b0, ONE_Q14}) &&
      normals.normal_x >= -$signed({1'b0, ONE_Q14}))
    else $error("normal component out of range");

endmodule

`default_nettype wire

FILE: sim/tb_heightmap_normal_stencil.sv
// Self-checking testbench for heightmap_normal_stencil: random raster frames in,
// normals checked against an exact integer predictor. Depends on hmn_pkg, hmn_ifs.
`timescale 1ns / 1ps

typedef struct {
  logic [12:0]        column;
  logic [15:0]        row;
  logic signed [15:0] normal_x;
  logic [14:0]        normal_y;
  logic signed [15:0] normal_z;
  logic               last_of_run;
} normal_word_t;

class normal_scoreboard;
  logic signed [23:0] older_heights[8192];
  logic signed [23:0] newer_heights[8192];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [13:0]        row_length;
  logic [15:0]        row_count;
  logic [7:0]         spacing;
  normal_word_t       pending_normals[$];
  int                 errors;

  function void reset_state();
    for (int i = 0; i < 8192; i++) begin
      older_heights[i] = '0;
      newer_heights[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    row_length = hmn_pkg::ROW_LENGTH_RST;
    row_count = hmn_pkg::ROW_COUNT_RST;
    spacing = hmn_pkg::SPACING_RST;
    errors = 0;
  endfunction

  function void write_reg(hmn_pkg::cfg_reg_t idx, logic [15:0] value);
    case (idx)
      hmn_pkg::REG_ROW_LENGTH:   row_length = value[13:0];
      hmn_pkg::REG_ROW_COUNT:    row_count = value;
      hmn_pkg::REG_GRID_SPACING: spacing = value[7:0];
      default: ;
    endcase
  endfunction

  // Largest q in 0..16384 with (2q-1)^2 * sq_len <= (2 * mag * 16384)^2
  function logic [14:0] round_q14(longint unsigned mag, logic [127:0] sq_len);
    logic [127:0] n2, rhs, t, lhs;
    int unsigned lo, hi, mid;
    n2 = 128'(mag) << 15;
    rhs = n2 * n2;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 128'(2 * mid - 1);
      lhs = sq_len * (t * t);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function void push_normal(int unsigned c, int unsigned r, longint nx, longint ny,
                            longint nz);
    normal_word_t w;
    w.column = c[12:0];
    w.row = r[15:0];
    w.normal_x = nx[15:0];
    w.normal_y = ny[14:0];
    w.normal_z = nz[15:0];
    w.last_of_run = 1'b0;
    pending_normals = {pending_normals, w};
  endfunction

  // Advance the raster position and queue the normals this sample causes
  function void note_sample(logic signed [23:0] h);
    int unsigned len, cnt, sp, c, r, n;
    longint dx, dz, nx, ny, nz;
    longint unsigned mx, mz, up;
    logic [127:0] sq;
    len = (row_length == 0) ? 1 : row_length;
    cnt = (row_count == 0) ? 1 : row_count;
    sp = (spacing == 0) ? 1 : spacing;
    n = 0;
    if (len > 8192) len = 8192;
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= cnt) row_pos = 0;
    c = col_pos;
    r = row_pos;
    if (r >= 1) begin
      nx = 0;
      ny = 16384;
      nz = 0;
      if (r - 1 != 0 && c != 0 && c != len - 1) begin
        dx = longint'(older_heights[c-1]) - longint'(newer_heights[c+1]);
        dz = longint'(older_heights[c]) - longint'(h);
        up = longint'(sp) * 512;
        mx = (dx < 0) ? -dx : dx;
        mz = (dz < 0) ? -dz : dz;
        sq = 128'(mx) * 128'(mx) + 128'(up) * 128'(up) + 128'(mz) * 128'(mz);
        nx = round_q14(mx, sq);
        nz = round_q14(mz, sq);
        ny = round_q14(up, sq);
        if (dx < 0) nx = -nx;
        if (dz < 0) nz = -nz;
      end
      push_normal(c, r - 1, nx, ny, nz);
      n++;
    end
    if (r == cnt - 1) begin
      push_normal(c, r, 0, 16384, 0);
      n++;
    end
    if (n > 0) pending_normals[$].last_of_run = 1'b1;
    older_heights[c] = newer_heights[c];
    newer_heights[c] = h;
    col_pos = c + 1;
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= cnt) row_pos = 0;
    end
  endfunction

  function void check_normal(normal_word_t got);
    normal_word_t exp_w;
    if (pending_normals.size() == 0) begin
      $error("unexpected normal word col=%0d row=%0d", got.column, got.row);
      errors++;
      return;
    end
    exp_w = pending_normals.pop_front();
    if (got.column !== exp_w.column) begin
      $error("column: expected %0d, got %0d", exp_w.column, got.column);
      errors++;
    end
    if (got.row !== exp_w.row) begin
      $error("row: expected %0d, got %0d", exp_w.row, got.row);
      errors++;
    end
    if (got.normal_x !== exp_w.normal_x) begin
      $error("normal_x: expected %0d, got %0d", exp_w.normal_x, got.normal_x);
      errors++;
    end
    if (got.normal_y !== exp_w.normal_y) begin
      $error("normal_y: expected %0d, got %0d", exp_w.normal_y, got.normal_y);
      errors++;
    end
    if (got.normal_z !== exp_w.normal_z) begin
      $error("normal_z: expected %0d, got %0d", exp_w.normal_z, got.normal_z);
      errors++;
    end
    if (got.last_of_run !== exp_w.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", exp_w.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction
endclass

module tb_heightmap_normal_stencil;
  import hmn_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;  // a bit over the pipeline latency

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned cycle_count = 0;
  int unsigned random_items;
  bit gaps_enabled;
  bit stalls_enabled;
  int unsigned stall_left;
  normal_scoreboard sb;
  normal_word_t seen;

  hmn_height_if samples_if ();
  hmn_normal_if normals_if ();

  heightmap_normal_stencil u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .normals   (normals_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output backpressure: mostly ready, short stalls, an occasional long one
  always @(posedge clk) begin
    if (rst) begin
      normals_if.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      normals_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_enabled && $urandom_range(0, 99) < 20) begin
      normals_if.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      normals_if.ready <= 1'b1;
    end
  end

  // Check every normal word at the edge where it moves
  always @(posedge clk) begin
    if (!rst && normals_if.valid && normals_if.ready) begin
      seen.column = normals_if.column;
      seen.row = normals_if.row;
      seen.normal_x = normals_if.normal_x;
      seen.normal_y = normals_if.normal_y;
      seen.normal_z = normals_if.normal_z;
      seen.last_of_run = normals_if.last_of_run;
      sb.check_normal(seen);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_enabled || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mix of full-range, near-flat, extreme and near-zero heights
  function automatic logic signed [23:0] pick_height(logic signed [23:0] base);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 24'($urandom);
    if (roll < 80) return base + $signed(24'($urandom_range(0, 2047)) - 24'sd1024);
    if (roll < 90) return ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
    return 24'($urandom_range(0, 255)) - 24'sd128;
  endfunction

  // Hold valid high across back-to-back words; drop it only for a gap
  task automatic send_height(logic signed [23:0] h);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.height_sample <= h;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_sample(h);
  endtask

  // Pause input until every expected normal has come out, then let the pipe empty
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (sb.pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] len, logic [15:0] cnt, logic [15:0] sp);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    sb.write_reg(REG_ROW_LENGTH, len);
    cfg_index <= REG_ROW_COUNT;
    cfg_data <= cnt;
    @(posedge clk);
    sb.write_reg(REG_ROW_COUNT, cnt);
    cfg_index <= REG_GRID_SPACING;
    cfg_data <= sp;
    @(posedge clk);
    sb.write_reg(REG_GRID_SPACING, sp);
    cfg_write <= 1'b0;
  endtask

  // Program, stream a number of words, drain
  task automatic run_phase(logic [15:0] len, logic [15:0] cnt, logic [15:0] sp,
                           int unsigned words);
    logic signed [23:0] base;
    program_regs(len, cnt, sp);
    base = 24'($urandom);
    for (int unsigned i = 0; i < words; i++) begin
      send_height(pick_height(base));
      if ($urandom_range(0, 31) == 0) base = 24'($urandom);
    end
    drain();
  endtask

  function automatic int unsigned eff_len(logic [15:0] len);
    if (len[13:0] == 0) return 1;
    if (len[13:0] > 8192) return 8192;
    return len[13:0];
  endfunction

  function automatic int unsigned eff_cnt(logic [15:0] cnt);
    return (cnt == 0) ? 1 : cnt;
  endfunction

  initial begin
    logic signed [23:0] corner [9];
    logic [15:0] len, cnt, sp;
    int unsigned words;
    sb = new();
    sb.reset_state();
    gaps_enabled = 1'b0;
    stalls_enabled = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ROW_LENGTH;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.height_sample = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest interior grid with extreme heights, then steepest slopes
    corner = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
               24'sh800000, 24'sh000000, 24'sh7FFFFF,
               24'sh7FFFFF, 24'sh800000, 24'sh800000};
    program_regs(16'd3, 16'd3, 16'd255);
    foreach (corner[i]) send_height(corner[i]);
    drain();
    program_regs(16'd3, 16'd3, 16'd1);
    foreach (corner[i]) send_height(corner[i]);
    drain();

    gaps_enabled = 1'b1;
    stalls_enabled = 1'b1;
    // Degenerate sizes: zero length/count/spacing, lengths one and two
    run_phase(16'd0, 16'd0, 16'd0, 1);
    run_phase(16'd1, 16'd4, 16'd7, 4);
    run_phase(16'd2, 16'd3, 16'd128, 6);
    run_phase(16'd5, 16'd0, 16'd3, 5);

    // Largest row count: part of a frame, then shrink the count so it wraps
    run_phase(16'd3, 16'd65535, 16'd2, 300);
    run_phase(16'd3, 16'd3, 16'd9, 9);

    // Widest rows, written exactly and saturating from above the maximum, as
    // single-row frames; then one 1x1 frame to return to a frame start
    run_phase(16'd8192, 16'd1, 16'd1, 40);
    run_phase(16'd16383, 16'd1, 16'd200, 40);
    run_phase(16'd1, 16'd1, 16'd1, 1);

    // Random frames; each phase ends on a frame boundary so rows stay consistent
    random_items = 0;
    while (random_items < 1600) begin
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                        : 16'($urandom_range(3, 40));
      cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                        : 16'($urandom_range(3, 8));
      case ($urandom_range(0, 3))
        0: sp = 16'd1;
        1: sp = 16'd255;
        2: sp = 16'd0;
        default: sp = 16'($urandom_range(1, 255));
      endcase
      gaps_enabled = ($urandom_range(0, 3) != 0);
      stalls_enabled = ($urandom_range(0, 3) != 0);
      words = eff_len(len) * eff_cnt(cnt) * $urandom_range(1, 2);
      run_phase(len, cnt, sp, words);
      random_items += words;
    end

    drain();
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
